/* rtl/ubsf_pkg.sv */
package ubsf_pkg;

    localparam int BYTE_DEPTH   = 64;
    localparam int SAMPLE_DEPTH = 64;
    localparam int BYTE_AW      = $clog2(BYTE_DEPTH);
    localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);

    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 10;
    localparam int LOW_W    = SAMPLE_W - BYTE_W;

    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_RX         = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP_BYTE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_SAMPLE = 2'd2;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH_BYTE,
        OP_PUSH_SAMPLE,
        OP_POP_BYTE,
        OP_POP_SAMPLE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] data;
    } cmd_t;

    function automatic logic [BYTE_AW-1:0] byte_wrap(input logic [BYTE_AW-1:0] p);
        return (p == BYTE_AW'(BYTE_DEPTH - 1)) ? '0 : p + BYTE_AW'(1);
    endfunction

    function automatic logic [SAMPLE_AW-1:0] sample_wrap(input logic [SAMPLE_AW-1:0] p);
        return (p == SAMPLE_AW'(SAMPLE_DEPTH - 1)) ? '0 : p + SAMPLE_AW'(1);
    endfunction

endpackage

/* rtl/ubsf_ram.sv */
module ubsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/ubsf_front.sv */
module ubsf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ubsf_pkg::FUNC_W-1:0]   func,
    input  logic [ubsf_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          ten_bit_mode,
    output logic                          cmd_valid,
    output ubsf_pkg::cmd_t                cmd,
    input  logic                          cmd_ready
);

    logic [ubsf_pkg::BYTE_W-1:0] held_reg, held_next;
    logic                        await_reg, await_next;
    logic                        accept;

    assign in_ready = cmd_ready;
    assign accept   = in_valid && cmd_ready;

    always_comb begin
        held_next = held_reg;
        await_next = await_reg;
        cmd_valid = 1'b0;
        cmd.op = ubsf_pkg::OP_PUSH_BYTE;
        cmd.data = {{ubsf_pkg::LOW_W{1'b0}}, rx_byte};
        case (func)
            ubsf_pkg::FUNC_RX: begin
                if (!ten_bit_mode) begin
                    cmd_valid = in_valid;
                end else if (!await_reg) begin
                    if (accept) begin
                        held_next = rx_byte;
                        await_next = 1'b1;
                    end
                end else begin
                    cmd_valid = in_valid;
                    cmd.op = ubsf_pkg::OP_PUSH_SAMPLE;
                    cmd.data = {held_reg, rx_byte[ubsf_pkg::LOW_W-1:0]};
                    if (accept) begin
                        await_next = 1'b0;
                    end
                end
            end
            ubsf_pkg::FUNC_POP_BYTE: begin
                cmd_valid = in_valid;
                cmd.op = ubsf_pkg::OP_POP_BYTE;
            end
            ubsf_pkg::FUNC_POP_SAMPLE: begin
                cmd_valid = in_valid;
                cmd.op = ubsf_pkg::OP_POP_SAMPLE;
            end
            default: begin
                cmd_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        if (!aresetn) begin
            await_reg <= 1'b0;
        end else begin
            await_reg <= await_next;
        end
    end

endmodule

/* rtl/ubsf_cmd_queue.sv */
module ubsf_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  ubsf_pkg::cmd_t wr_cmd,
    output logic           rd_valid,
    input  logic           rd_ready,
    output ubsf_pkg::cmd_t rd_cmd
);

    ubsf_pkg::cmd_t                  slot_reg [ubsf_pkg::CMDQ_DEPTH];
    logic [ubsf_pkg::CMDQ_AW-1:0]    wptr_reg, wptr_next;
    logic [ubsf_pkg::CMDQ_AW-1:0]    rptr_reg, rptr_next;
    logic [ubsf_pkg::CMDQ_CW-1:0]    count_reg, count_next;
    logic                            do_wr, do_rd;

    assign wr_ready = count_reg != ubsf_pkg::CMDQ_CW'(ubsf_pkg::CMDQ_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = slot_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        count_next = count_reg;
        if (do_wr) begin
            wptr_next = (wptr_reg == ubsf_pkg::CMDQ_AW'(ubsf_pkg::CMDQ_DEPTH - 1)) ?
                        '0 : wptr_reg + ubsf_pkg::CMDQ_AW'(1);
        end
        if (do_rd) begin
            rptr_next = (rptr_reg == ubsf_pkg::CMDQ_AW'(ubsf_pkg::CMDQ_DEPTH - 1)) ?
                        '0 : rptr_reg + ubsf_pkg::CMDQ_AW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + ubsf_pkg::CMDQ_CW'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - ubsf_pkg::CMDQ_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wptr_reg] <= wr_cmd;
        end
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/ubsf_back.sv */
module ubsf_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  ubsf_pkg::cmd_t                 cmd,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           pop_valid,
    output logic [ubsf_pkg::SAMPLE_W-1:0]  pop_data
);

    logic [ubsf_pkg::BYTE_AW-1:0]   bwp_reg, bwp_next, brp_reg, brp_next, bwp_inc;
    logic [ubsf_pkg::SAMPLE_AW-1:0] swp_reg, swp_next, srp_reg, srp_next, swp_inc;
    logic                           pend_reg, pend_hit_reg, pend_smp_reg;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_hit_reg;
    logic [ubsf_pkg::SAMPLE_W-1:0]  out_data_reg;
    logic                           is_pop, fire;
    logic                           push_b, push_s, pop_b, pop_s;
    logic                           b_empty, s_empty;
    logic [ubsf_pkg::BYTE_W-1:0]    b_rdata;
    logic [ubsf_pkg::SAMPLE_W-1:0]  s_rdata;

    assign is_pop    = cmd.op inside {ubsf_pkg::OP_POP_BYTE, ubsf_pkg::OP_POP_SAMPLE};
    assign cmd_ready = is_pop ? (!pend_reg && (!out_valid_reg || out_ready)) : 1'b1;
    assign fire      = cmd_valid && cmd_ready;
    assign push_b    = fire && (cmd.op == ubsf_pkg::OP_PUSH_BYTE);
    assign push_s    = fire && (cmd.op == ubsf_pkg::OP_PUSH_SAMPLE);
    assign pop_b     = fire && (cmd.op == ubsf_pkg::OP_POP_BYTE);
    assign pop_s     = fire && (cmd.op == ubsf_pkg::OP_POP_SAMPLE);
    assign b_empty   = brp_reg == bwp_reg;
    assign s_empty   = srp_reg == swp_reg;
    assign bwp_inc   = ubsf_pkg::byte_wrap(bwp_reg);
    assign swp_inc   = ubsf_pkg::sample_wrap(swp_reg);

    // full push drops the oldest entry
    always_comb begin
        bwp_next = bwp_reg;
        brp_next = brp_reg;
        swp_next = swp_reg;
        srp_next = srp_reg;
        if (push_b) begin
            bwp_next = bwp_inc;
            if (bwp_inc == brp_reg) begin
                brp_next = ubsf_pkg::byte_wrap(brp_reg);
            end
        end
        if (pop_b && !b_empty) begin
            brp_next = ubsf_pkg::byte_wrap(brp_reg);
        end
        if (push_s) begin
            swp_next = swp_inc;
            if (swp_inc == srp_reg) begin
                srp_next = ubsf_pkg::sample_wrap(srp_reg);
            end
        end
        if (pop_s && !s_empty) begin
            srp_next = ubsf_pkg::sample_wrap(srp_reg);
        end
    end

    always_comb begin
        if (pend_reg) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    ubsf_ram #(
        .WIDTH (ubsf_pkg::BYTE_W),
        .DEPTH (ubsf_pkg::BYTE_DEPTH)
    ) u_byte_ram (
        .aclk  (aclk),
        .we    (push_b),
        .waddr (bwp_reg),
        .wdata (cmd.data[ubsf_pkg::BYTE_W-1:0]),
        .re    (pop_b && !b_empty),
        .raddr (brp_reg),
        .rdata (b_rdata)
    );

    ubsf_ram #(
        .WIDTH (ubsf_pkg::SAMPLE_W),
        .DEPTH (ubsf_pkg::SAMPLE_DEPTH)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (push_s),
        .waddr (swp_reg),
        .wdata (cmd.data),
        .re    (pop_s && !s_empty),
        .raddr (srp_reg),
        .rdata (s_rdata)
    );

    always_ff @(posedge aclk) begin
        pend_hit_reg <= pop_b ? !b_empty : !s_empty;
        pend_smp_reg <= pop_s;
        if (pend_reg) begin
            out_hit_reg <= pend_hit_reg;
            if (!pend_hit_reg) begin
                out_data_reg <= '0;
            end else if (pend_smp_reg) begin
                out_data_reg <= s_rdata;
            end else begin
                out_data_reg <= {{ubsf_pkg::LOW_W{1'b0}}, b_rdata};
            end
        end
        if (!aresetn) begin
            bwp_reg <= '0;
            brp_reg <= '0;
            swp_reg <= '0;
            srp_reg <= '0;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            bwp_reg <= bwp_next;
            brp_reg <= brp_next;
            swp_reg <= swp_next;
            srp_reg <= srp_next;
            pend_reg <= pop_b || pop_s;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_valid = out_hit_reg;
    assign pop_data  = out_data_reg;

    a_pend_single: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |=> !pend_reg)
        else $error("read issued on back-to-back cycles");

    a_pend_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |=> out_valid_reg)
        else $error("pending read did not reach output register");

    a_pend_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (!out_valid_reg || out_ready))
        else $error("read data would overwrite an untaken result");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_b && b_empty) |=> (pend_reg && !pend_hit_reg))
        else $error("empty byte pop not reported as empty");

endmodule

/* rtl/uart_byte_and_sample_fifos_top.sv */
// UART receive stream into a byte FIFO and a 10-bit sample FIFO.
// Slave channel s_*: one transfer per operation. s_tuser selects it
// (received byte, pop byte FIFO, pop sample FIFO; code 3 is dropped) and
// carries the mode pin; s_tdata carries the received byte.
// In 10-bit mode two received bytes form one sample: high eight bits from
// the first, low two bits from the second.
// Master channel m_*: one transfer per pop. m_tuser is 1 when an entry was
// returned, 0 when the FIFO was empty (m_tdata then zero).
// Both FIFOs hold up to 63 entries; a push into a full FIFO drops the oldest.
// A push is taken every cycle unless pops waiting ahead of it fill the
// command queue; a pop occupies the memory read port and output register,
// so the next pop waits until it is done. A pop passes through the 2-entry
// command queue, the registered RAM read and the output register to m_tvalid.
// Reset (aresetn low, synchronous) empties both FIFOs, the command queue and
// clears a pending half-sample. While m_tready is low the result is held,
// further pops wait in the command queue, and s_tready drops once the queue
// is full.
module uart_byte_and_sample_fifos_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [2:0]  s_tuser,   // [1:0] func, [2] ten_bit_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] pop_data, [15:10] zero
    output logic [0:0]  m_tuser    // [0] pop_valid
);

    logic                           cmd_valid, cmd_ready;
    ubsf_pkg::cmd_t                 cmd;
    logic                           q_valid, q_ready;
    ubsf_pkg::cmd_t                 q_cmd;
    logic                           pop_valid;
    logic [ubsf_pkg::SAMPLE_W-1:0]  pop_data;

    ubsf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .func         (s_tuser[1:0]),
        .rx_byte      (s_tdata),
        .ten_bit_mode (s_tuser[2]),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_ready    (cmd_ready)
    );

    ubsf_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (cmd_valid),
        .wr_ready (cmd_ready),
        .wr_cmd   (cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd)
    );

    ubsf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    assign m_tdata = {{(16 - ubsf_pkg::SAMPLE_W){1'b0}}, pop_data};
    assign m_tuser = pop_valid;

endmodule
